>>> rtl/sri_pkg.sv
// Shared types and constants for the stepped ramp interpolator.
// Holds the sequencer state type, the per-lane control bundle and field layout.
// No dependencies.
`default_nettype none

package sri_pkg;

    // Field layout of the stream beats
    localparam int MAX_LANES      = 4;
    localparam int FIELD_BITS     = 32;
    localparam int STEP_BITS      = 16;
    localparam int STEPS_LSB      = MAX_LANES * FIELD_BITS;
    localparam int TDATA_BITS     = STEPS_LSB + STEP_BITS;

    // Defaults for the top level parameters
    localparam int DEF_LANES      = 4;
    localparam int DEF_VALUE_BITS = 32;

    // Operation codes carried in tuser
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } sri_state_t;

    // Per-lane commands from the sequencer
    typedef struct packed {
        logic load;    // latch a new target
        logic snap;    // value takes the target
        logic start;   // begin one ramp step division
    } sri_lane_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/stepped_ramp_interpolator.sv
// Stepped ramp interpolator, top level: sequencer, lanes and output merge.
// Set, or tick with zero count, passes from accept through the emit state to the
// output register; tick with nonzero count first waits in the divide state for the
// bit-serial divider in each lane. One item in flight, so no new beat is accepted
// until the result of the last one is in the output register, and m_tready low
// can stall it in the emit state. Reset clears values, targets and count.
`default_nettype none

module stepped_ramp_interpolator #(
    parameter int LANES      = sri_pkg::DEF_LANES,
    parameter int VALUE_BITS = sri_pkg::DEF_VALUE_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // target_x, target_y, target_z, target_w, ramp_steps
    input  wire logic [sri_pkg::TDATA_BITS-1:0]    s_tdata,
    // operation
    input  wire logic                              s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // value_x, value_y, value_z, value_w, steps_left
    output logic [sri_pkg::TDATA_BITS-1:0]         m_tdata
);

    import sri_pkg::*;

    sri_state_t               state_reg, state_next;
    logic [STEP_BITS-1:0]     count_reg, count_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [TDATA_BITS-1:0]    m_tdata_reg, m_tdata_next;
    logic                     accept;
    logic                     emit;
    logic                     div_done;
    logic [STEP_BITS-1:0]     steps_in;
    sri_lane_ctrl_t           lane_ctrl;
    logic [LANES-1:0]         done_vec;
    logic [TDATA_BITS-1:0]    merged;

    assign steps_in = s_tdata[STEPS_LSB +: STEP_BITS];
    assign accept   = s_tvalid && s_tready;
    assign div_done = done_vec[0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = (s_tuser == OP_TICK && count_reg != '0) ? ST_DIVIDE : ST_EMIT;
            ST_DIVIDE:
                if (div_done)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (emit)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready        = (state_reg == ST_IDLE);
        emit            = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);
        lane_ctrl.load  = accept && (s_tuser == OP_SET);
        lane_ctrl.snap  = accept && ((s_tuser == OP_SET && steps_in == '0) ||
                                     (s_tuser == OP_TICK && count_reg == '0));
        lane_ctrl.start = accept && (s_tuser == OP_TICK) && (count_reg != '0);
    end

    // Step count
    always_comb
    begin
        count_next = count_reg;
        if (lane_ctrl.load)
            count_next = steps_in;
        else if (div_done)
            count_next = count_reg - STEP_BITS'(1);
    end

    // Lanes
    generate
        for (genvar i = 0; i < MAX_LANES; i++)
        begin : g_lane
            if (i < LANES)
            begin : g_on
                logic signed [FIELD_BITS-1:0] lane_out;
                sri_lane #(
                    .VALUE_BITS (VALUE_BITS)
                ) u_lane (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (lane_ctrl),
                    .target_in (s_tdata[i*FIELD_BITS +: FIELD_BITS]),
                    .steps     (count_reg),
                    .done      (done_vec[i]),
                    .value_out (lane_out)
                );
                assign merged[i*FIELD_BITS +: FIELD_BITS] = lane_out;
            end
            else
            begin : g_off
                assign merged[i*FIELD_BITS +: FIELD_BITS] = '0;
            end
        end
    endgenerate

    assign merged[STEPS_LSB +: STEP_BITS] = count_reg;

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = merged;
        end
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_vec == {LANES{done_vec[0]}})
        else $error("lanes finished out of step");

    a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lane_ctrl.start |-> count_reg != '0)
        else $error("division started with zero count");

    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVIDE)
        else $error("division finished outside divide state");

    a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |=> count_reg == $past(count_reg) - STEP_BITS'(1))
        else $error("count not lowered after a ramp step");

    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output loaded outside emit state");

endmodule

`default_nettype wire

>>> rtl/sri_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Unsigned dividend over a nonzero unsigned divisor; uses no package.
`default_nettype none

module sri_div #(
    parameter int DIVIDEND_BITS = 33,
    parameter int DIVISOR_BITS  = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic                          done,
    output logic [DIVIDEND_BITS-1:0]      quotient
);

    localparam int CW = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [DIVISOR_BITS:0]    rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_BITS:0]    shifted;
    logic                     fits;

    // Load on start, else one restoring step while busy
    always_comb
    begin
        shifted   = {rem_reg[DIVISOR_BITS-1:0], quo_reg[DIVIDEND_BITS-1]};
        fits      = shifted >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DIVIDEND_BITS);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, dsr_reg}) : shifted;
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> rtl/sri_lane.sv
// One ramp lane: value and target registers, signed step through a shared-shape
// divider, target clamping and 32-bit output saturation. Uses sri_pkg, sri_div.
`default_nettype none

module sri_lane #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire sri_pkg::sri_lane_ctrl_t               ctrl,
    input  wire logic signed [sri_pkg::FIELD_BITS-1:0] target_in,
    input  wire logic        [sri_pkg::STEP_BITS-1:0]  steps,
    output logic                                       done,
    output logic signed [sri_pkg::FIELD_BITS-1:0]      value_out
);

    import sri_pkg::*;

    localparam int DW = VALUE_BITS + 1;

    logic signed [VALUE_BITS-1:0] value_reg, value_next;
    logic signed [VALUE_BITS-1:0] target_reg, target_next;
    logic                         neg_reg, neg_next;
    logic signed [VALUE_BITS-1:0] tgt_clamped;
    logic signed [DW-1:0]         diff;
    logic        [DW-1:0]         mag;
    logic        [DW-1:0]         quo;
    logic signed [DW-1:0]         step;
    logic                         div_done;

    // Target brought into the held width
    generate
        if (VALUE_BITS >= FIELD_BITS)
        begin : g_tgt_wide
            assign tgt_clamped = VALUE_BITS'(target_in);
        end
        else
        begin : g_tgt_narrow
            localparam logic signed [FIELD_BITS-1:0] VMAX =
                FIELD_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
            localparam logic signed [FIELD_BITS-1:0] VMIN =
                FIELD_BITS'(-(64'sd1 <<< (VALUE_BITS - 1)));
            always_comb
            begin
                priority if (target_in > VMAX)
                    tgt_clamped = VALUE_BITS'(VMAX);
                else if (target_in < VMIN)
                    tgt_clamped = VALUE_BITS'(VMIN);
                else
                    tgt_clamped = VALUE_BITS'(target_in);
            end
        end
    endgenerate

    // Distance to target as sign and magnitude
    assign diff = {target_reg[VALUE_BITS-1], target_reg} - {value_reg[VALUE_BITS-1], value_reg};
    assign mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);

    sri_div #(
        .DIVIDEND_BITS (DW),
        .DIVISOR_BITS  (STEP_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.start),
        .dividend (mag),
        .divisor  (steps),
        .done     (div_done),
        .quotient (quo)
    );

    // Quotient truncated toward zero; sum stays between value and target
    assign step = neg_reg ? -$signed(quo) : $signed(quo);

    always_comb
    begin
        value_next  = value_reg;
        target_next = target_reg;
        neg_next    = neg_reg;
        if (ctrl.load)
            target_next = tgt_clamped;
        if (ctrl.start)
            neg_next = diff[DW-1];
        priority if (ctrl.snap && ctrl.load)
            value_next = tgt_clamped;
        else if (ctrl.snap)
            value_next = target_reg;
        else if (div_done)
            value_next = VALUE_BITS'({value_reg[VALUE_BITS-1], value_reg} + step);
        else
            value_next = value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg  <= '0;
            target_reg <= '0;
            neg_reg    <= 1'b0;
        end
        else
        begin
            value_reg  <= value_next;
            target_reg <= target_next;
            neg_reg    <= neg_next;
        end
    end

    // Output field saturates to 32 bits
    generate
        if (VALUE_BITS > FIELD_BITS)
        begin : g_out_wide
            localparam logic signed [VALUE_BITS-1:0] OMAX = VALUE_BITS'(64'sd2147483647);
            localparam logic signed [VALUE_BITS-1:0] OMIN = VALUE_BITS'(-64'sd2147483648);
            always_comb
            begin
                priority if (value_reg > OMAX)
                    value_out = FIELD_BITS'(OMAX);
                else if (value_reg < OMIN)
                    value_out = FIELD_BITS'(OMIN);
                else
                    value_out = FIELD_BITS'(value_reg);
            end
        end
        else
        begin : g_out_narrow
            assign value_out = FIELD_BITS'(value_reg);
        end
    endgenerate

    assign done = div_done;

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for stepped_ramp_interpolator: directed table, then random ramps.
// Predicts every result beat in Q16.16 and checks it under random idling and backpressure.
// Depends on sri_pkg and the stepped_ramp_interpolator RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb;

    import sri_pkg::*;

    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int DRAIN_WAIT  = 40;    // final wait after the last drain

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // Beat layouts, lane 0 (x) in the lowest bits, step count on top
    typedef struct packed {
        logic [15:0]      ramp_steps;
        logic [3:0][31:0] target;
    } ramp_item_t;

    typedef struct packed {
        logic [15:0]      steps_left;
        logic [3:0][31:0] value;
    } ramp_result_t;

    // Directed row: operation, typed flag, stimulus, typed result
    typedef struct packed {
        logic         op;
        logic         has_want;
        ramp_item_t   stim;
        ramp_result_t want;
    } ramp_row_t;

    // Stimulus and result fields: {steps, w, z, y, x}
    localparam ramp_row_t RAMP_ROWS [21] = '{
        // tick right after reset: everything settles at zero
        {OP_TICK, 1'b1, {16'h0000, 32'h0, 32'h0, 32'h0, 32'h0},
                        {16'h0000, 32'h0, 32'h0, 32'h0, 32'h0}},
        // jump to the extremes
        {OP_SET,  1'b1, {16'h0000, 32'hFFFF_0000, 32'h0, Q_MIN, Q_MAX},
                        {16'h0000, 32'hFFFF_0000, 32'h0, Q_MIN, Q_MAX}},
        // set with a count: values hold
        {OP_SET,  1'b1, {16'h0001, 32'h0001_0000, 32'h1, Q_MAX, Q_MIN},
                        {16'h0001, 32'hFFFF_0000, 32'h0, Q_MIN, Q_MAX}},
        // last tick covers the full swing; unused fields all ones
        {OP_TICK, 1'b1, {16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                        {16'h0000, 32'h0001_0000, 32'h1, Q_MAX, Q_MIN}},
        // tick at zero count snaps to the targets
        {OP_TICK, 1'b1, {16'h0000, 32'h0, 32'h0, 32'h0, 32'h0},
                        {16'h0000, 32'h0001_0000, 32'h1, Q_MAX, Q_MIN}},
        // longest ramp
        {OP_SET,  1'b1, {16'hFFFF, 32'h7FFF_0000, 32'hFFFF_FFFF, Q_MIN, Q_MAX},
                        {16'hFFFF, 32'h0001_0000, 32'h1, Q_MAX, Q_MIN}},
        {OP_TICK, 1'b0, 144'h0, 144'h0},
        {OP_TICK, 1'b0, 144'h0, 144'h0},
        {OP_TICK, 1'b0, 144'h0, 144'h0},
        // jump mid-ramp back to zero
        {OP_SET,  1'b1, {16'h0000, 32'h0, 32'h0, 32'h0, 32'h0},
                        {16'h0000, 32'h0, 32'h0, 32'h0, 32'h0}},
        // short ramp with truncation toward zero on both signs
        {OP_SET,  1'b1, {16'h0003, 32'hFFFF_FFF9, 32'h7, 32'hFFFF_FFF6, 32'hA},
                        {16'h0003, 32'h0, 32'h0, 32'h0, 32'h0}},
        {OP_TICK, 1'b0, 144'h0, 144'h0},
        {OP_TICK, 1'b0, 144'h0, 144'h0},
        {OP_TICK, 1'b0, 144'h0, 144'h0},
        {OP_TICK, 1'b1, {16'h0000, 32'h0, 32'h0, 32'h0, 32'h0},
                        {16'h0000, 32'hFFFF_FFF9, 32'h7, 32'hFFFF_FFF6, 32'hA}},
        {OP_SET,  1'b0, {16'h0002, 32'hDEAD_BEEF, 32'h0, 32'h1234_5678, 32'h8000_0001}, 144'h0},
        {OP_TICK, 1'b0, 144'h0, 144'h0},
        {OP_TICK, 1'b0, 144'h0, 144'h0},
        {OP_SET,  1'b0, {16'h0005, 32'h0, Q_MAX, Q_MIN, 32'h5555_5555}, 144'h0},
        {OP_TICK, 1'b0, 144'h0, 144'h0},
        {OP_SET,  1'b1, {16'h0000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444},
                        {16'h0000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444}}
    };

    localparam string LANE_TAG [4] = '{"x", "y", "z", "w"};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_BITS-1:0] s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;

    // Predicted lane state
    logic [3:0][31:0] lane_val;
    logic [3:0][31:0] lane_tgt;
    logic [15:0]      ramp_left;

    ramp_result_t ramp_due_q [$];

    int src_idle_pct = 33;
    int snk_idle_pct = 58;
    int stall_token  = 0;
    int stall_seen   = 0;
    int hold_left    = 0;
    int fail_cnt     = 0;
    int n_checked    = 0;
    int n_set        = 0;
    int n_tick       = 0;
    int n_snap       = 0;
    int n_landed     = 0;

    stepped_ramp_interpolator i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Next lane values and count after one accepted beat
    function automatic ramp_result_t ramp_advance(input logic op, input ramp_item_t it);
        ramp_result_t r;
        longint       gap;
        if (op == OP_SET)
        begin
            n_set++;
            ramp_left = it.ramp_steps;
            for (int i = 0; i < 4; i++)
            begin
                lane_tgt[i] = it.target[i];
                if (ramp_left == 16'd0)
                    lane_val[i] = lane_tgt[i];
            end
        end
        else if (ramp_left == 16'd0)
        begin
            n_tick++;
            n_snap++;
            lane_val = lane_tgt;
        end
        else
        begin
            n_tick++;
            for (int i = 0; i < 4; i++)
            begin
                gap = longint'($signed(lane_tgt[i])) - longint'($signed(lane_val[i]));
                lane_val[i] = 32'(longint'($signed(lane_val[i])) + gap / longint'(ramp_left));
            end
            ramp_left = ramp_left - 16'd1;
            if (ramp_left == 16'd0)
                n_landed++;
        end
        r.value      = lane_val;
        r.steps_left = ramp_left;
        return r;
    endfunction

    // Fully random beat, also used as the ignored payload of ticks
    function automatic ramp_item_t noise_item();
        ramp_item_t r;
        r.ramp_steps = 16'($urandom);
        for (int i = 0; i < 4; i++)
            r.target[i] = $urandom;
        return r;
    endfunction

    // Drive one beat and hold it until accepted; valid stays high afterwards
    task automatic offer_beat(input logic op, input ramp_item_t it);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= it;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic issue_item(input logic op, input ramp_item_t it,
                              input logic has_want, input ramp_result_t want);
        ramp_result_t pred;
        offer_beat(op, it);
        pred = ramp_advance(op, it);
        ramp_due_q.push_back(has_want ? want : pred);
    endtask

    // Pause the sender until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (ramp_due_q.size() != 0)
            @(posedge clk);
    endtask

    // Mostly set-then-ticks sequences, with some random beats mixed in
    task automatic ramp_burst(input int n_items);
        int         sent;
        int         ticks;
        ramp_item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                issue_item(1'($urandom_range(1)), noise_item(), 1'b0, '0);
                sent++;
            end
            else
            begin
                case ($urandom_range(15))
                    0:       it.ramp_steps = 16'd0;
                    1:       it.ramp_steps = 16'($urandom_range(65535));
                    2:       it.ramp_steps = 16'hFFFF;
                    default: it.ramp_steps = 16'($urandom_range(10, 1));
                endcase
                for (int i = 0; i < 4; i++)
                begin
                    case ($urandom_range(7))
                        0:       it.target[i] = Q_MAX;
                        1:       it.target[i] = Q_MIN;
                        2:       it.target[i] = 32'h0;
                        3:       it.target[i] = 32'($urandom_range(200)) - 32'd100;
                        default: it.target[i] = $urandom;
                    endcase
                end
                issue_item(OP_SET, it, 1'b0, '0);
                sent++;
                ticks = (it.ramp_steps > 16'd12) ? $urandom_range(14)
                                                 : $urandom_range(it.ramp_steps + 2);
                for (int k = 0; k < ticks; k++)
                begin
                    issue_item(OP_TICK, noise_item(), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (stall_token != stall_seen)
        begin
            stall_seen <= stall_token;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        ramp_result_t want;
        ramp_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (ramp_due_q.size() == 0)
            begin
                fail_cnt++;
                $error("result beat with nothing expected: %h", got);
            end
            else
            begin
                want = ramp_due_q.pop_front();
                n_checked++;
                for (int i = 0; i < 4; i++)
                begin
                    if (got.value[i] !== want.value[i])
                    begin
                        fail_cnt++;
                        $error("value_%s: expected %0d, got %0d", LANE_TAG[i],
                               $signed(want.value[i]), $signed(got.value[i]));
                    end
                end
                if (got.steps_left !== want.steps_left)
                begin
                    fail_cnt++;
                    $error("steps_left: expected %0d, got %0d",
                           want.steps_left, got.steps_left);
                end
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        lane_val  = '0;
        lane_tgt  = '0;
        ramp_left = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: sender idles a third of the time, receiver more than half
        foreach (RAMP_ROWS[r])
            issue_item(RAMP_ROWS[r].op, RAMP_ROWS[r].stim, RAMP_ROWS[r].has_want,
                       RAMP_ROWS[r].want);
        ramp_burst(320);
        drain_results();

        // receiver holds off while the sender keeps offering beats
        stall_token <= stall_token + 1;
        ramp_burst(10);
        drain_results();

        // phase 2: idling swapped
        src_idle_pct = 58;
        snk_idle_pct = 33;
        ramp_burst(230);
        drain_results();

        // phase 3: back to back
        src_idle_pct = 0;
        snk_idle_pct = 0;
        ramp_burst(230);
        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d set and %0d tick beats, %0d snaps at zero count, %0d ramps landed",
                 n_set, n_tick, n_snap, n_landed);
        $display("%0d result beats checked, %0d mismatches", n_checked, fail_cnt);
        if (fail_cnt == 0)
            $display("[stepped_ramp_interpolator] OK");
        else
            $display("[stepped_ramp_interpolator] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", ramp_due_q.size());
        $display("[stepped_ramp_interpolator] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
